### sv/packed_item_set_table_assert.svh
// ----------------------------------------------------------------------------
// packed_item_set_table assertion macros
// Shared concurrent assertion forms for the packed item set table checks.
// ----------------------------------------------------------------------------
`ifndef PACKED_ITEM_SET_TABLE_ASSERT_SVH
`define PACKED_ITEM_SET_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted (active low)
`define PIST_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("packed_item_set_table: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted (active low)
`define PIST_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("packed_item_set_table: next-cycle check failed");

`endif

### sv/pist_pkg.sv
// ----------------------------------------------------------------------------
// pist_pkg
// Constants, request codes and controller/datapath types of the packed
// item set table.
// ----------------------------------------------------------------------------
`default_nettype none

package pist_pkg;

    // Table geometry
    localparam int SLOTS  = 8;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LEAD_W = $clog2(SLOTS + 1);

    // Field widths
    localparam int ITEM_W = 16;
    localparam int TYPE_W = 3;
    localparam int SIDX_W = 3;
    localparam int CNT_W  = 4;

    localparam logic [CNT_W-1:0] CNT_MAX  = 4'hF;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // Request codes
    localparam logic [TYPE_W-1:0] REQ_READ   = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_REMOVE = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_CLEAR  = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_QUERY  = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_TOGGLE = 3'd4;
    localparam logic [TYPE_W-1:0] REQ_SWAP   = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_SHIFT,
        ST_INSERT,
        ST_DONE
    } pist_state_t;

    // Write data select
    typedef enum logic [1:0] {
        WR_ZERO,
        WR_NEXT,
        WR_A,
        WR_B
    } pist_wsel_t;

    // Read address select
    typedef enum logic [1:0] {
        RD_PTR,
        RD_NEXT,
        RD_SLOT
    } pist_rsel_t;

    typedef struct packed {
        logic       load;       // capture request, restart scan
        logic       clear_all;  // empty every slot
        logic       read_slot;  // latch read data as item_out
        logic       scan;       // scan cycle: track first empty slot
        logic       step;       // advance the slot pointer
        logic       wr_en;      // write one slot
        logic       wr_fz;      // write at first empty slot, not pointer
        pist_wsel_t wr_sel;
        pist_rsel_t rd_sel;
        logic       clr_ok;     // result fails
        logic       set_pres;   // item found
        logic       finish;     // load the result register
    } pist_cmd_t;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic              hit_a;     // read data equals item A
        logic              hit_b;     // read data equals item B
        logic              rd_zero;   // read data is an empty slot
        logic              at_last;   // pointer on the last slot
        logic              out_busy;  // result register still held
    } pist_stat_t;

endpackage

`default_nettype wire

### sv/pist_ctrl.sv
// ----------------------------------------------------------------------------
// pist_ctrl
// Request sequencer: walks the slot pointer through scan, shift and insert
// phases and hands the finished result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pist_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  pist_pkg::pist_stat_t  stat,
    output pist_pkg::pist_cmd_t   cmd
);
    import pist_pkg::*;

    pist_state_t state_reg;
    pist_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.wr_sel  = WR_ZERO;
        cmd.rd_sel  = RD_PTR;
        s_ready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                case (stat.req_type)
                    REQ_READ: begin
                        cmd.rd_sel    = RD_SLOT;
                        cmd.read_slot = 1'b1;
                        state_next    = ST_DONE;
                    end
                    REQ_CLEAR: begin
                        cmd.clear_all = 1'b1;
                        state_next    = ST_DONE;
                    end
                    REQ_REMOVE, REQ_QUERY, REQ_TOGGLE, REQ_SWAP: begin
                        state_next = ST_SCAN;
                    end
                    default: begin
                        cmd.clr_ok = 1'b1;
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                case (stat.req_type)
                    REQ_QUERY: begin
                        if (stat.hit_a) begin
                            cmd.set_pres = 1'b1;
                            state_next   = ST_DONE;
                        end else if (stat.at_last) begin
                            state_next = ST_DONE;
                        end else begin
                            cmd.step = 1'b1;
                        end
                    end
                    REQ_REMOVE: begin
                        if (stat.hit_a) begin
                            state_next = ST_SHIFT;
                        end else if (stat.at_last) begin
                            state_next = ST_DONE;
                        end else begin
                            cmd.step = 1'b1;
                        end
                    end
                    REQ_TOGGLE: begin
                        if (stat.hit_a) begin
                            state_next = ST_SHIFT;
                        end else if (stat.at_last) begin
                            // absent: insert unless the last slot is taken
                            if (!stat.rd_zero) begin
                                cmd.clr_ok = 1'b1;
                                state_next = ST_DONE;
                            end else begin
                                state_next = ST_INSERT;
                            end
                        end else begin
                            cmd.step = 1'b1;
                        end
                    end
                    REQ_SWAP: begin
                        // search stops at the first empty slot
                        if (stat.rd_zero) begin
                            cmd.clr_ok = 1'b1;
                            state_next = ST_DONE;
                        end else if (stat.hit_a) begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_sel = WR_B;
                            state_next = ST_DONE;
                        end else if (stat.hit_b) begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_sel = WR_A;
                            state_next = ST_DONE;
                        end else if (stat.at_last) begin
                            cmd.clr_ok = 1'b1;
                            state_next = ST_DONE;
                        end else begin
                            cmd.step = 1'b1;
                        end
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SHIFT: begin
                // move the next slot down; toggle stops at an empty slot
                cmd.rd_sel = RD_NEXT;
                cmd.wr_en  = 1'b1;
                if (stat.at_last || (stat.req_type == REQ_TOGGLE && stat.rd_zero)) begin
                    cmd.wr_sel = WR_ZERO;
                    state_next = ST_DONE;
                end else begin
                    cmd.wr_sel = WR_NEXT;
                    cmd.step   = 1'b1;
                end
            end
            ST_INSERT: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_fz  = 1'b1;
                cmd.wr_sel = WR_A;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!stat.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/pist_dpath.sv
// ----------------------------------------------------------------------------
// pist_dpath
// Slot storage, request registers, one slot comparator, the leading count
// and the result register of the packed item set table.
// ----------------------------------------------------------------------------
`default_nettype none

module pist_dpath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  pist_pkg::pist_cmd_t                cmd,
    output pist_pkg::pist_stat_t               stat,
    input  wire logic [pist_pkg::TYPE_W-1:0]   s_req_type,
    input  wire logic [pist_pkg::ITEM_W-1:0]   s_item_a,
    input  wire logic [pist_pkg::ITEM_W-1:0]   s_item_b,
    input  wire logic [pist_pkg::SIDX_W-1:0]   s_slot_index,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_success,
    output logic                               m_present,
    output logic [pist_pkg::ITEM_W-1:0]        m_item_out,
    output logic [pist_pkg::CNT_W-1:0]         m_filled_count
);
    import pist_pkg::*;

    // Request registers
    logic [TYPE_W-1:0] req_type_reg;
    logic [ITEM_W-1:0] item_a_reg;
    logic [ITEM_W-1:0] item_b_reg;
    logic [SIDX_W-1:0] slot_idx_reg;

    // Scan state
    logic [IDX_W-1:0]  ptr_reg;
    logic [IDX_W-1:0]  fz_reg;
    logic              fz_valid_reg;

    // Result under construction
    logic              ok_reg;
    logic              pres_reg;
    logic [ITEM_W-1:0] item_reg;

    // Slot storage
    logic [ITEM_W-1:0] slot_reg [SLOTS];

    // Result register
    logic              m_valid_reg;
    logic              m_success_reg;
    logic              m_present_reg;
    logic [ITEM_W-1:0] m_item_reg;
    logic [CNT_W-1:0]  m_count_reg;

    logic [IDX_W:0]    rd_addr;
    logic              rd_in_range;
    logic              idx_ok;
    logic [ITEM_W-1:0] rd_data;
    logic [IDX_W-1:0]  wr_addr;
    logic [ITEM_W-1:0] wr_data;
    logic [LEAD_W-1:0] lead;
    logic [CNT_W-1:0]  count_sat;

    // Read port: pointer, pointer + 1, or the requested slot
    always_comb begin
        case (cmd.rd_sel)
            RD_PTR:  rd_addr = {1'b0, ptr_reg};
            RD_NEXT: rd_addr = {1'b0, ptr_reg} + (IDX_W + 1)'(1);
            RD_SLOT: rd_addr = (IDX_W + 1)'(slot_idx_reg);
            default: rd_addr = {1'b0, ptr_reg};
        endcase
    end

    assign idx_ok      = (32'(slot_idx_reg) < SLOTS);
    assign rd_in_range = (32'(rd_addr) < SLOTS) && ((cmd.rd_sel != RD_SLOT) || idx_ok);
    assign rd_data     = rd_in_range ? slot_reg[rd_addr[IDX_W-1:0]] : '0;

    // Status to the sequencer
    always_comb begin
        stat.req_type = req_type_reg;
        stat.hit_a    = (rd_data == item_a_reg);
        stat.hit_b    = (rd_data == item_b_reg);
        stat.rd_zero  = (rd_data == '0);
        stat.at_last  = (ptr_reg == LAST_IDX);
        stat.out_busy = m_valid_reg && !m_ready;
    end

    // Write port
    assign wr_addr = cmd.wr_fz ? fz_reg : ptr_reg;

    always_comb begin
        case (cmd.wr_sel)
            WR_ZERO: wr_data = '0;
            WR_NEXT: wr_data = rd_data;
            WR_A:    wr_data = item_a_reg;
            WR_B:    wr_data = item_b_reg;
            default: wr_data = '0;
        endcase
    end

    // Slot storage, cleared at reset and by a clear request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < SLOTS; k++) begin
                slot_reg[k] <= '0;
            end
        end else if (cmd.clear_all) begin
            for (int k = 0; k < SLOTS; k++) begin
                slot_reg[k] <= '0;
            end
        end else if (cmd.wr_en) begin
            slot_reg[wr_addr] <= wr_data;
        end
    end

    // Leading filled run: index of the first empty slot
    always_comb begin
        lead = LEAD_W'(SLOTS);
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (slot_reg[k] == '0) begin
                lead = LEAD_W'(k);
            end
        end
    end

    assign count_sat = (32'(lead) > 32'(CNT_MAX)) ? CNT_MAX : CNT_W'(lead);

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fz_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.load) begin
                fz_valid_reg <= 1'b0;
            end else if (cmd.scan && stat.rd_zero && !fz_valid_reg) begin
                fz_valid_reg <= 1'b1;
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Request, scan and result payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_type_reg <= s_req_type;
            item_a_reg   <= s_item_a;
            item_b_reg   <= s_item_b;
            slot_idx_reg <= s_slot_index;
        end
        if (cmd.load) begin
            ptr_reg <= '0;
        end else if (cmd.step) begin
            ptr_reg <= ptr_reg + IDX_W'(1);
        end
        if (cmd.scan && stat.rd_zero && !fz_valid_reg) begin
            fz_reg <= ptr_reg;
        end
        if (cmd.load) begin
            ok_reg <= 1'b1;
        end else if (cmd.clr_ok) begin
            ok_reg <= 1'b0;
        end
        if (cmd.load) begin
            pres_reg <= 1'b0;
        end else if (cmd.set_pres) begin
            pres_reg <= 1'b1;
        end
        if (cmd.load) begin
            item_reg <= '0;
        end else if (cmd.read_slot) begin
            item_reg <= rd_data;
        end
        if (cmd.finish) begin
            m_success_reg <= ok_reg;
            m_present_reg <= pres_reg;
            m_item_reg    <= item_reg;
            m_count_reg   <= count_sat;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_success      = m_success_reg;
    assign m_present      = m_present_reg;
    assign m_item_out     = m_item_reg;
    assign m_filled_count = m_count_reg;

endmodule

`default_nettype wire

### sv/packed_item_set_table.sv
// ----------------------------------------------------------------------------
// packed_item_set_table
// Packed list of 16-bit item codes with read, remove, clear, query, toggle
// and swap requests; one result beat per request beat.
// ----------------------------------------------------------------------------
// Usage:
//   Request beats enter on s_* (valid/ready); each yields exactly one result
//   beat on m_* carrying success, present, item_out and the filled count.
//   One request is worked at a time. A single slot comparator walks the
//   list one slot per cycle; the work per request is:
//     read, clear, undefined code : no scan, straight to the result
//     query, swap                 : scan up to the deciding slot
//     remove, toggle              : scan, then shift or insert
//   s_ready rises again in the same cycle that the result goes valid, so the
//   next request can be taken while that result may still wait in the
//   output register. When the receiver stalls, the finished request waits
//   in its last step until the output register frees up; nothing is
//   dropped.
//   Reset (aresetn low, synchronous) empties every slot and drops any
//   pending result; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_item_set_table (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [pist_pkg::TYPE_W-1:0]   s_req_type,
    input  wire logic [pist_pkg::ITEM_W-1:0]   s_item_a,
    input  wire logic [pist_pkg::ITEM_W-1:0]   s_item_b,
    input  wire logic [pist_pkg::SIDX_W-1:0]   s_slot_index,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_success,
    output logic                               m_present,
    output logic [pist_pkg::ITEM_W-1:0]        m_item_out,
    output logic [pist_pkg::CNT_W-1:0]         m_filled_count
);
    import pist_pkg::*;

    pist_cmd_t  cmd;
    pist_stat_t stat;

    // Sequencer
    pist_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Storage and compare datapath
    pist_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_req_type     (s_req_type),
        .s_item_a       (s_item_a),
        .s_item_b       (s_item_b),
        .s_slot_index   (s_slot_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_success      (m_success),
        .m_present      (m_present),
        .m_item_out     (m_item_out),
        .m_filled_count (m_filled_count)
    );

endmodule

`default_nettype wire

### sv/pist_checker.sv
// ----------------------------------------------------------------------------
// pist_checker
// Port-level checks of the packed item set table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "packed_item_set_table_assert.svh"

module pist_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    input  wire logic                          s_ready,
    input  wire logic [pist_pkg::TYPE_W-1:0]   s_req_type,
    input  wire logic [pist_pkg::ITEM_W-1:0]   s_item_a,
    input  wire logic [pist_pkg::ITEM_W-1:0]   s_item_b,
    input  wire logic [pist_pkg::SIDX_W-1:0]   s_slot_index,
    input  wire logic                          m_valid,
    input  wire logic                          m_ready,
    input  wire logic                          m_success,
    input  wire logic                          m_present,
    input  wire logic [pist_pkg::ITEM_W-1:0]   m_item_out,
    input  wire logic [pist_pkg::CNT_W-1:0]    m_filled_count
);
    import pist_pkg::*;

    logic [ITEM_W+CNT_W+1:0] m_payload;
    logic                    s_beat;

    assign m_payload = {m_success, m_present, m_item_out, m_filled_count};
    assign s_beat    = s_valid && s_ready && (s_req_type != '1 || s_item_a != s_item_b
                       || s_slot_index != '1 || 1'b1);

    // A stalled result beat holds its value
    `PIST_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_payload))

    // One request at a time: the block is busy right after taking a beat
    `PIST_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_beat, !s_ready)

    // A found item only comes with a successful result
    `PIST_ASSERT_SAME(a_present_ok, aclk, aresetn, m_valid && m_present, m_success)

    // A read slot result never carries a presence flag
    `PIST_ASSERT_SAME(a_item_no_pres, aclk, aresetn, m_valid && (m_item_out != '0), !m_present)

    // The leading run never exceeds the table size
    `PIST_ASSERT_SAME(a_count_range, aclk, aresetn, m_valid, 32'(m_filled_count) <= SLOTS)

endmodule

bind packed_item_set_table pist_checker u_pist_checker (.*);

`default_nettype wire
